FILE: src/ece_pkg.sv
// ece_pkg: shared types and constants of the easing curve evaluator
// holds the register codes, the mode and curve enums and the sine table builder
// no dependencies
package ece_pkg;

   localparam int PROGRESS_W = 17;
   localparam int EASED_W    = 18;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   // pi/2 in q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EASE_MODE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_SELECT = 4'd1;

   typedef enum logic [1:0] {
      EASE_PASS   = 2'd0,
      EASE_IN     = 2'd1,
      EASE_OUT    = 2'd2,
      EASE_IN_OUT = 2'd3
   } ease_mode_type;

   typedef enum logic [2:0] {
      CURVE_LINEAR  = 3'd0,
      CURVE_QUAD    = 3'd1,
      CURVE_CUBIC   = 3'd2,
      CURVE_QUARTIC = 3'd3,
      CURVE_QUINTIC = 3'd4,
      CURVE_BACK    = 3'd5,
      CURVE_ELASTIC = 3'd6
   } curve_type;

   // one quarter-wave sine entry, sin(i*pi/(2*2^table_bits)), rounded to frac_bits
   // evaluated at elaboration only, through a q30 taylor series
   function automatic logic [63:0] sine_entry(input int i, input int frac_bits,
                                              input int table_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] s;
      int sh;
      x    = (64'(i) * HALF_PI_Q30) >> table_bits;
      x2   = (x * x) >> 30;
      term = x;
      pos  = '0;
      neg  = '0;
      for (int k = 0; k < 12; k++) begin
         if ((k % 2) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
         term = ((term * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
      end
      s  = pos - neg;
      sh = 30 - frac_bits;
      return (s + (64'd1 << (sh - 1))) >> sh;
   endfunction

endpackage

FILE: src/easing_curve_evaluator.sv
// easing_curve_evaluator: pipelined easing curve evaluator, top level
// depends on ece_pkg for register codes, enums and the sine table builder
// single module, seven register stages
// Each req beat carries a progress t (unsigned, FRAC_BITS fraction bits,
// clamped to 1.0) and yields exactly one rsp beat with the eased value,
// signed with FRAC_BITS fraction bits and saturated to the 18-bit range.
// The block takes one beat per clock while the rsp side does not stall.
// rsp_valid rises once the beat reaches the output register. The seven
// stages are: clamp and
// mode fold, square plus sine phase, cube/fourth power plus sine table
// lookup, fifth power and polynomial sums, elastic envelope multiply,
// elastic sine multiply, curve select with mode unfold and saturation.
// At most one fixed-point multiply sits in any stage path, which sets the clock.
// A stalled rsp side holds the stages that carry data; empty stages keep
// filling, so req_ready only drops when every stage holds a beat.
// The sine comes from a quarter-wave table of 2^SINE_TABLE_BITS + 1
// constant entries, built at elaboration and read through a register.
// csr_ready is always high. ease_mode (index 0, reset in) and curve_select
// (index 1, reset quad): user writes only while pipeline is empty; unchecked.
module easing_curve_evaluator #(
   parameter int FRAC_BITS       = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // progress beats in
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ece_pkg::PROGRESS_W-1:0]      req_progress,
   // eased value beats out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ece_pkg::EASED_W-1:0]  rsp_eased_value,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ece_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ece_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import ece_pkg::*;

   localparam int TW   = FRAC_BITS + 1;               // unsigned 0..1.0
   localparam int PW   = (PROGRESS_W > TW) ? PROGRESS_W : TW;
   localparam int FW   = FRAC_BITS + 3;               // signed curve values
   localparam int RW   = FRAC_BITS + 4;               // signed mode results
   localparam int SW   = (RW > EASED_W) ? RW : EASED_W;
   localparam int TB   = SINE_TABLE_BITS;
   localparam int AW   = TB + 1;                      // table address
   localparam int QD   = (1 << TB) + 1;               // table depth
   localparam int PFW  = TW + TB + 4;                 // sine phase product
   localparam int NSTG = 7;

   localparam logic [TW-1:0]        ONE_T   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [TW-1:0]        HALF_T  = {2'b01, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [FW-1:0] TWO_F   = {3'b010, {FRAC_BITS{1'b0}}};
   localparam logic signed [RW-1:0] ONE_R   = {4'b0001, {FRAC_BITS{1'b0}}};
   localparam logic signed [RW-1:0] LSB_R   = 1;
   localparam logic [AW-1:0]        QSIZE_A = {1'b1, {TB{1'b0}}};
   localparam logic signed [SW-1:0] MAX_S   = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] MIN_S   = SW'(OUT_MIN);

   // unsigned product of two values in 0..1.0, rounded half up
   function automatic logic [TW-1:0] fx_umul(input logic [TW-1:0] a, input logic [TW-1:0] b);
      logic [2*TW-1:0] p;
      p = (2*TW)'(a) * (2*TW)'(b) + (2*TW)'(HALF_T);
      return p[FRAC_BITS +: TW];
   endfunction

   // signed product, rounded half up, floor shift
   function automatic logic signed [FW-1:0] fx_smul(input logic signed [FW-1:0] a,
                                                     input logic signed [FW-1:0] b);
      logic signed [2*FW-1:0] p;
      logic signed [2*FW-1:0] h;
      h = (2*FW)'($signed({1'b0, HALF_T}));
      p = (2*FW)'(a) * (2*FW)'(b) + h;
      return $signed(p[FRAC_BITS +: FW]);
   endfunction

   function automatic logic signed [FW-1:0] to_fw(input logic [TW-1:0] v);
      return $signed(FW'(v));
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   ease_mode_type ease_mode_ff;
   curve_type     curve_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_mode_ff <= EASE_IN;
         curve_ff     <= CURVE_QUAD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EASE_MODE:    ease_mode_ff <= ease_mode_type'(csr_wdata[1:0]);
            CSR_CURVE_SELECT: curve_ff     <= curve_type'(csr_wdata[2:0]);
            default: ;   // writes past the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // sine quarter-wave table, constant content
   // ---------------------------------------------------------------
   logic [TW-1:0] sine_rom [QD];

   for (genvar g = 0; g < QD; g++) begin : g_rom
      assign sine_rom[g] = TW'(sine_entry(g, FRAC_BITS, TB));
   end

   // ---------------------------------------------------------------
   // stage valids and per-stage advance, bubbles collapse
   // ---------------------------------------------------------------
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] stage_en;

   always_comb begin
      stage_en[NSTG-1] = !valid_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NSTG-1];

   // ---------------------------------------------------------------
   // stage 1: clamp t, fold the mode into the curve argument u
   // ---------------------------------------------------------------
   logic [TW-1:0] s1_t_in, s1_u_in;
   logic          s1_lo_in;
   logic [TW-1:0] s1_t_ff, s1_u_ff;
   logic          s1_lo_ff;

   always_comb begin
      logic [PW-1:0] prog_ext;
      logic [TW-1:0] rest;
      prog_ext = PW'(req_progress);
      s1_t_in  = (prog_ext >= PW'(ONE_T)) ? ONE_T : prog_ext[TW-1:0];
      s1_lo_in = s1_t_in < HALF_T;
      rest     = ONE_T - s1_t_in;
      case (ease_mode_ff)
         EASE_OUT:    s1_u_in = rest;
         // 2t below the midpoint, 2 - 2t above it
         EASE_IN_OUT: s1_u_in = s1_lo_in ? {s1_t_in[TW-2:0], 1'b0} : {rest[TW-2:0], 1'b0};
         default:     s1_u_in = s1_t_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_t_ff  <= s1_t_in;
         s1_u_ff  <= s1_u_in;
         s1_lo_ff <= s1_lo_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: u^2, sine phase 3.5*pi*u mapped to quadrant and address
   // ---------------------------------------------------------------
   logic [TW-1:0] s2_t2_in;
   logic [AW-1:0] s2_addr_in;
   logic          s2_neg_in;
   logic [TW-1:0] s2_t_ff, s2_u_ff, s2_t2_ff;
   logic          s2_lo_ff, s2_neg_ff;
   logic [AW-1:0] s2_addr_ff;

   always_comb begin
      logic [PFW-1:0]  ph;
      logic [TB+1:0]   pidx;
      logic [TB-1:0]   idx;
      s2_t2_in = fx_umul(s1_u_ff, s1_u_ff);
      // phase in table steps: 7*u*Q rounded, modulo a full wave
      ph   = (((PFW'(s1_u_ff) << 3) - PFW'(s1_u_ff)) << TB) + PFW'(HALF_T);
      pidx = ph[FRAC_BITS +: TB + 2];
      idx  = pidx[TB-1:0];
      // odd quadrants run the table backwards, the lower half-wave is negative
      s2_addr_in = pidx[TB] ? (QSIZE_A - {1'b0, idx}) : {1'b0, idx};
      s2_neg_in  = pidx[TB+1];
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_t_ff    <= s1_t_ff;
         s2_u_ff    <= s1_u_ff;
         s2_lo_ff   <= s1_lo_ff;
         s2_t2_ff   <= s2_t2_in;
         s2_addr_ff <= s2_addr_in;
         s2_neg_ff  <= s2_neg_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: u^3, u^4, registered table read
   // ---------------------------------------------------------------
   logic [TW-1:0] s3_t_ff, s3_u_ff, s3_t2_ff, s3_t3_ff, s3_t4_ff, s3_sine_ff;
   logic          s3_lo_ff, s3_neg_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_t_ff    <= s2_t_ff;
         s3_u_ff    <= s2_u_ff;
         s3_lo_ff   <= s2_lo_ff;
         s3_t2_ff   <= s2_t2_ff;
         s3_t3_ff   <= fx_umul(s2_t2_ff, s2_u_ff);
         s3_t4_ff   <= fx_umul(s2_t2_ff, s2_t2_ff);
         s3_sine_ff <= sine_rom[s2_addr_ff];
         s3_neg_ff  <= s2_neg_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: u^5, back curve, elastic envelope polynomial, -sin
   // ---------------------------------------------------------------
   logic signed [FW-1:0] s4_back_in, s4_arg_in, s4_msine_in;
   logic [TW-1:0]        s4_t_ff, s4_u_ff, s4_t2_ff, s4_t3_ff, s4_t4_ff, s4_t5_ff;
   logic                 s4_lo_ff;
   logic signed [FW-1:0] s4_back_ff, s4_arg_ff, s4_msine_ff;

   always_comb begin
      s4_back_in  = to_fw(s3_t3_ff) + to_fw(s3_t2_ff) - to_fw(s3_u_ff);
      // 2u^3 + u^2 - 4u + 2, stays positive on 0..1
      s4_arg_in   = (to_fw(s3_t3_ff) <<< 1) + to_fw(s3_t2_ff) - (to_fw(s3_u_ff) <<< 2) + TWO_F;
      s4_msine_in = s3_neg_ff ? to_fw(s3_sine_ff) : -to_fw(s3_sine_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_t_ff     <= s3_t_ff;
         s4_u_ff     <= s3_u_ff;
         s4_lo_ff    <= s3_lo_ff;
         s4_t2_ff    <= s3_t2_ff;
         s4_t3_ff    <= s3_t3_ff;
         s4_t4_ff    <= s3_t4_ff;
         s4_t5_ff    <= fx_umul(s3_t4_ff, s3_u_ff);
         s4_back_ff  <= s4_back_in;
         s4_arg_ff   <= s4_arg_in;
         s4_msine_ff <= s4_msine_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: elastic envelope u^2 * poly, pick the non-elastic curve
   // ---------------------------------------------------------------
   logic signed [FW-1:0] s5_poly_in;
   logic [TW-1:0]        s5_t_ff;
   logic                 s5_lo_ff;
   logic signed [FW-1:0] s5_poly_ff, s5_scale_ff, s5_msine_ff;

   always_comb begin
      case (curve_ff)
         CURVE_QUAD:    s5_poly_in = to_fw(s4_t2_ff);
         CURVE_CUBIC:   s5_poly_in = to_fw(s4_t3_ff);
         CURVE_QUARTIC: s5_poly_in = to_fw(s4_t4_ff);
         CURVE_QUINTIC: s5_poly_in = to_fw(s4_t5_ff);
         CURVE_BACK:    s5_poly_in = s4_back_ff;
         default:       s5_poly_in = to_fw(s4_u_ff);   // linear and unused code
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_t_ff     <= s4_t_ff;
         s5_lo_ff    <= s4_lo_ff;
         s5_poly_ff  <= s5_poly_in;
         s5_scale_ff <= fx_smul(to_fw(s4_t2_ff), s4_arg_ff);
         s5_msine_ff <= s4_msine_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: elastic = envelope * -sin
   // ---------------------------------------------------------------
   logic [TW-1:0]        s6_t_ff;
   logic                 s6_lo_ff;
   logic signed [FW-1:0] s6_poly_ff, s6_elastic_ff;

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s6_t_ff       <= s5_t_ff;
         s6_lo_ff      <= s5_lo_ff;
         s6_poly_ff    <= s5_poly_ff;
         s6_elastic_ff <= fx_smul(s5_scale_ff, s5_msine_ff);
      end
   end

   // ---------------------------------------------------------------
   // stage 7: unfold the mode, saturate, output register
   // ---------------------------------------------------------------
   logic signed [EASED_W-1:0] eased_in;
   logic signed [EASED_W-1:0] eased_ff;

   always_comb begin
      logic signed [FW-1:0] f;
      logic signed [RW-1:0] f_r;
      logic signed [RW-1:0] hf;
      logic signed [RW-1:0] r;
      logic signed [SW-1:0] r_s;
      f   = (curve_ff == CURVE_ELASTIC) ? s6_elastic_ff : s6_poly_ff;
      f_r = RW'(f);
      hf  = (f_r + LSB_R) >>> 1;   // half, rounded up
      case (ease_mode_ff)
         EASE_IN:     r = f_r;
         EASE_OUT:    r = ONE_R - f_r;
         EASE_IN_OUT: r = s6_lo_ff ? hf : ONE_R - hf;
         default:     r = $signed(RW'(s6_t_ff));   // passthrough of clamped t
      endcase
      r_s = SW'(r);
      if (r_s > MAX_S) begin
         r_s = MAX_S;
      end else if (r_s < MIN_S) begin
         r_s = MIN_S;
      end
      eased_in = r_s[EASED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         eased_ff <= eased_in;
      end
   end

   assign rsp_eased_value = eased_ff;

endmodule
